[sv/sem_pkg.sv]
// Shared types, constants and register codes for the Sobel edge magnitude block.
package sem_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 1024;
  localparam int CoeffBits  = 4;
  localparam int KernelTaps = 9;
  localparam int AddrW      = $clog2(MaxWidth);
  localparam int DimW       = 11;
  localparam int CfgW       = 36;
  localparam int SumW       = 16;
  localparam int AbsW       = 15;
  localparam int SqW        = 2 * AbsW;
  localparam int RadW       = SqW + 1;
  localparam int RootSteps  = RadW / 2 + 1;
  localparam int StepW      = $clog2(RootSteps);

  typedef enum logic [2:0] {
    REG_COEFF_X      = 3'd0,
    REG_COEFF_Y      = 3'd1,
    REG_THRESHOLD    = 3'd2,
    REG_LINE_WIDTH   = 3'd3,
    REG_FRAME_HEIGHT = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_SQUARE,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic mac;
    logic square;
    logic root_init;
    logic root_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic produce;
    logic root_done;
    logic out_free;
  } status_t;

endpackage

[sv/sem_ram.sv]
// Generic simple dual-port RAM with registered read.
module sem_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/sem_ctrl.sv]
// Controller state machine sequencing one pixel through the datapath.
module sem_ctrl import sem_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_READ;
      ST_READ:      state_next = status.produce ? ST_MAC : ST_IDLE;
      ST_MAC:       state_next = ST_SQUARE;
      ST_SQUARE:    state_next = ST_ROOT_INIT;
      ST_ROOT_INIT: state_next = ST_ROOT;
      ST_ROOT:      if (status.root_done) state_next = ST_OUT;
      ST_OUT:       if (status.out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_READ:      cmd.update    = 1'b1;
      ST_MAC:       cmd.mac       = 1'b1;
      ST_SQUARE:    cmd.square    = 1'b1;
      ST_ROOT_INIT: cmd.root_init = 1'b1;
      ST_ROOT:      cmd.root_step = 1'b1;
      ST_OUT:       cmd.load_out  = status.out_free;
      default: ;
    endcase
  end

endmodule

[sv/sem_datapath.sv]
// Datapath: config registers, raster counters, line stores, window, MAC, root, output.
module sem_datapath import sem_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cmd_t            cmd,
  output status_t         status,
  input  logic [7:0]      pixel,
  input  logic            frame_start,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      magnitude,
  output logic            row_end,
  output logic            frame_end
);

  logic [CfgW-1:0] coeff_x, coeff_y;
  logic [7:0]      threshold;
  logic [DimW-1:0] line_width, frame_height;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_x      <= 36'd4848619503;
      coeff_y      <= 36'd4548780303;
      threshold    <= 8'd20;
      line_width   <= 11'd640;
      frame_height <= 11'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEFF_X:      coeff_x      <= cfg_data;
        REG_COEFF_Y:      coeff_y      <= cfg_data;
        REG_THRESHOLD:    threshold    <= cfg_data[7:0];
        REG_LINE_WIDTH:   line_width   <= cfg_data[DimW-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[DimW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame geometry
  logic [DimW-1:0] w_eff, h_eff;
  always_comb begin
    if (line_width < DimW'(3))             w_eff = DimW'(3);
    else if (line_width > DimW'(MaxWidth)) w_eff = DimW'(MaxWidth);
    else                                   w_eff = line_width;
    if (frame_height < DimW'(3))              h_eff = DimW'(3);
    else if (frame_height > DimW'(MaxHeight)) h_eff = DimW'(MaxHeight);
    else                                      h_eff = frame_height;
  end

  // Raster position of the incoming pixel
  logic [AddrW-1:0] col, row;
  logic [DimW-1:0]  c0, r0, c_next, r_next;
  always_comb begin
    c0 = frame_start ? '0 : DimW'(col);
    r0 = frame_start ? '0 : DimW'(row);
    if (c0 >= w_eff) begin
      c0 = '0;
      r0 = r0 + DimW'(1);
    end
    if (r0 >= h_eff) r0 = '0;
    c_next = c0 + DimW'(1);
    r_next = r0;
    if (c_next >= w_eff) begin
      c_next = '0;
      r_next = r0 + DimW'(1);
      if (r_next >= h_eff) r_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.accept) begin
      col <= c_next[AddrW-1:0];
      row <= r_next[AddrW-1:0];
    end
  end

  // Hold the accepted beat
  logic [7:0]       px;
  logic [AddrW-1:0] addr;
  logic             produce, last_col, last_row;
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px       <= pixel;
      addr     <= c0[AddrW-1:0];
      produce  <= (r0 >= DimW'(2)) && (c0 >= DimW'(2));
      last_col <= (c0 == w_eff - DimW'(1));
      last_row <= (r0 == h_eff - DimW'(1));
    end
  end

  // Line stores
  logic [7:0] a_rd, b_rd;
  sem_ram #(.Width(8), .Depth(MaxWidth)) u_store_a (
    .clk(clk), .we(cmd.update), .waddr(addr), .wdata(px),
    .re(cmd.accept), .raddr(c0[AddrW-1:0]), .rdata(a_rd)
  );
  sem_ram #(.Width(8), .Depth(MaxWidth)) u_store_b (
    .clk(clk), .we(cmd.update), .waddr(addr), .wdata(a_rd),
    .re(cmd.accept), .raddr(c0[AddrW-1:0]), .rdata(b_rd)
  );

  // Advance the 3x3 window by one column
  logic [7:0] win [KernelTaps];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KernelTaps; k++) win[k] <= '0;
    end else if (cmd.update) begin
      for (int k = 0; k < 6; k++) win[k] <= win[k+3];
      win[6] <= b_rd;
      win[7] <= a_rd;
      win[8] <= px;
    end
  end

  // Two correlations over the window
  logic signed [SumW-1:0] sx, sy, sx_sum, sy_sum;
  always_comb begin
    sx_sum = '0;
    sy_sum = '0;
    for (int k = 0; k < KernelTaps; k++) begin
      sx_sum = sx_sum + SumW'($signed(coeff_x[CoeffBits*k +: CoeffBits])
                             * $signed({1'b0, win[k]}));
      sy_sum = sy_sum + SumW'($signed(coeff_y[CoeffBits*k +: CoeffBits])
                             * $signed({1'b0, win[k]}));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac) begin
      sx <= sx_sum;
      sy <= sy_sum;
    end
  end

  // Square the absolute values
  logic [AbsW-1:0] ax, ay;
  logic [SqW-1:0]  sqx, sqy;
  assign ax = sx[SumW-1] ? AbsW'(-sx) : AbsW'(sx);
  assign ay = sy[SumW-1] ? AbsW'(-sy) : AbsW'(sy);
  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sqx <= ax * ax;
      sqy <= ay * ay;
    end
  end

  // Integer square root, two radicand bits per step
  logic [RadW-1:0]  rad, res, trial;
  logic [StepW-1:0] step;
  logic [RadW-1:0]  rbit;
  assign rbit  = RadW'(1) << (RadW - 1 - 2 * int'(step));
  assign trial = res + rbit;
  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rad  <= RadW'(sqx) + RadW'(sqy);
      res  <= '0;
      step <= '0;
    end else if (cmd.root_step) begin
      if (rad >= trial) begin
        rad <= rad - trial;
        res <= (res >> 1) + rbit;
      end else begin
        res <= res >> 1;
      end
      step <= step + StepW'(1);
    end
  end

  // Threshold and saturate
  logic [RadW-3:0] q;
  logic [7:0]      mag;
  assign q   = res[RadW-1:2];
  assign mag = (q < (RadW-2)'(threshold)) ? 8'd0 :
               (q > (RadW-2)'(255))       ? 8'd255 : q[7:0];

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      magnitude <= mag;
      row_end   <= last_col;
      frame_end <= last_col && last_row;
    end
  end

  assign status.produce   = produce;
  assign status.root_done = (step == StepW'(RootSteps - 1));
  assign status.out_free  = !out_valid || out_ready;

endmodule

[sv/sobel_edge_magnitude_threshold.sv]
// Top level of the Sobel edge magnitude block with threshold.
// Pixels are taken one at a time. A border pixel, which gives no result, is accepted and
// then used for the line-store read and window update. An interior pixel goes through
// accept, window update, correlation, squaring, root setup, 16 steps of the square-root
// unit and the output load; it waits longer while the output register still holds an
// untaken beat. Line stores are not cleared after reset.
module sobel_edge_magnitude_threshold import sem_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      pixel,
  input  logic            frame_start,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      magnitude,
  output logic            row_end,
  output logic            frame_end,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [CfgW-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  sem_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .status(status), .cmd(cmd)
  );

  sem_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .pixel(pixel), .frame_start(frame_start),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .magnitude(magnitude), .row_end(row_end), .frame_end(frame_end)
  );

endmodule

[sv/sem_checker.sv]
// Port-level assertions for the Sobel edge magnitude block, bound to the top level.
module sem_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] magnitude,
  input logic       row_end,
  input logic       frame_end
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(magnitude) && $stable(frame_end))
    else $error("stalled output beat changed");

  // Frame end only on a row end
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> row_end)
    else $error("frame end without row end");

  // One pixel in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind sobel_edge_magnitude_threshold sem_checker u_sem_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .magnitude(magnitude),
  .row_end(row_end), .frame_end(frame_end)
);

[tb/sobel_edge_magnitude_threshold_tb.sv]
// Self-checking testbench for the Sobel edge magnitude block with threshold.
module sobel_edge_magnitude_threshold_tb;
  import sem_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [7:0]      pixel = 8'd0;
  logic            frame_start = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [7:0]      magnitude;
  logic            row_end;
  logic            frame_end;
  logic            cfg_we = 1'b0;
  logic [2:0]      cfg_index = 3'd0;
  logic [CfgW-1:0] cfg_data = '0;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pix_beat_t;

  typedef struct packed {
    logic [7:0] magnitude;
    logic       row_end;
    logic       frame_end;
  } edge_beat_t;

  sobel_edge_magnitude_threshold DUT (.*);

  // Shadow copy of registers and pixel history
  logic [35:0] kx, ky;
  logic [7:0]  thr;
  logic [10:0] lw, fh;
  logic [7:0]  row_a [MaxWidth];
  logic [7:0]  row_b [MaxWidth];
  logic [7:0]  win [9];
  int unsigned col, row;

  pix_beat_t  pending_pixels[$];
  edge_beat_t expected_edges[$];
  int  errors = 0;
  int  results_seen = 0;
  int  pixels_sent = 0;
  bit  calm = 1'b0;
  bit  hold_off = 1'b0;
  int  hold_cycles = 0;
  longint cycles = 0;
  logic in_ready_q = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  function automatic int tap(input logic [35:0] k, input int i);
    logic signed [3:0] v;
    v = k[4*i +: 4];
    return int'(v);
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Advance the shadow image state by one pixel; push a result if interior
  task automatic predict_edge(input pix_beat_t p);
    int unsigned w, h, c, r;
    longint sx, sy;
    longint unsigned q;
    edge_beat_t e;
    w = (lw < 3) ? 3 : (lw > MaxWidth) ? MaxWidth : lw;
    h = (fh < 3) ? 3 : (fh > MaxHeight) ? MaxHeight : fh;
    if (p.frame_start) begin
      col = 0;
      row = 0;
    end
    if (col >= w) begin
      col = 0;
      row++;
    end
    if (row >= h) row = 0;
    c = col;
    r = row;
    for (int i = 0; i < 6; i++) win[i] = win[i+3];
    win[6] = row_b[c];
    win[7] = row_a[c];
    win[8] = p.pixel;
    row_b[c] = row_a[c];
    row_a[c] = p.pixel;
    if (r >= 2 && c >= 2) begin
      sx = 0;
      sy = 0;
      for (int i = 0; i < 9; i++) begin
        sx += tap(kx, i) * longint'(win[i]);
        sy += tap(ky, i) * longint'(win[i]);
      end
      if (sx < 0) sx = -sx;
      if (sy < 0) sy = -sy;
      q = root_floor(sx*sx + sy*sy) >> 2;
      if (q < thr) q = 0;
      else if (q > 255) q = 255;
      e.magnitude = q[7:0];
      e.row_end = (c == w - 1);
      e.frame_end = (c == w - 1) && (r == h - 1);
      expected_edges.push_back(e);
    end
    col = c + 1;
    if (col >= w) begin
      col = 0;
      row = r + 1;
      if (row >= h) row = 0;
    end
  endtask

  // Driver: offer pending pixels with random gaps
  int gap_in = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready_q) begin
        if (gap_in > 0 && !calm) begin
          gap_in <= gap_in - 1;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          pixel       <= pending_pixels[0].pixel;
          frame_start <= pending_pixels[0].frame_start;
          in_valid    <= 1'b1;
          void'(pending_pixels.pop_front());
          if (!calm && $urandom_range(0, 7) == 0) gap_in <= $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Capture input acceptance at the rising edge for the driver
  always @(posedge clk) begin
    in_ready_q <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      predict_edge('{pixel: pixel, frame_start: frame_start});
      pixels_sent++;
    end
  end

  // Receiver readiness: bursts of stalls, plus one long hold-off
  int gap_out = 0;
  always @(negedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (gap_out > 0) begin
      gap_out <= gap_out - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 7) == 0) gap_out <= $urandom_range(1, 15);
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    edge_beat_t e;
    if (!rst) cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (expected_edges.size() == 0) begin
        report_mismatch("unexpected beat", magnitude, -1);
      end else begin
        e = expected_edges.pop_front();
        if (magnitude !== e.magnitude) report_mismatch("magnitude", magnitude, e.magnitude);
        if (row_end !== e.row_end) report_mismatch("row_end", row_end, e.row_end);
        if (frame_end !== e.frame_end) report_mismatch("frame_end", frame_end, e.frame_end);
      end
      results_seen <= results_seen + 1;
    end
  end

  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COEFF_X:      kx  = val[35:0];
      REG_COEFF_Y:      ky  = val[35:0];
      REG_THRESHOLD:    thr = val[7:0];
      REG_LINE_WIDTH:   lw  = val[10:0];
      REG_FRAME_HEIGHT: fh  = val[10:0];
      default: ;
    endcase
  endtask

  // Hold until all queued pixels are taken and all results are back
  task automatic drain();
    while (pending_pixels.size() > 0 || in_valid || expected_edges.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Queue one frame, starting with a frame mark; random or directed content
  task automatic queue_frame(input int w, input int h, input int mode);
    pix_beat_t p;
    for (int i = 0; i < w * h; i++) begin
      p.frame_start = (i == 0);
      case (mode)
        0: p.pixel = 8'($urandom_range(0, 255));
        1: p.pixel = ((i % w) & 1) ? 8'hFF : 8'h00;
        default: p.pixel = ($urandom_range(0, 1)) ? 8'hFF : 8'h00;
      endcase
      pending_pixels.push_back(p);
    end
  endtask

  int w, h;
  initial begin
    pix_beat_t p;
    kx = 36'd4848619503;
    ky = 36'd4548780303;
    thr = 8'd20;
    lw = 11'd640;
    fh = 11'd480;
    for (int i = 0; i < 9; i++) win[i] = 8'd0;
    col = 0;
    row = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: smallest frame, extreme pixels and threshold zero
    write_reg(REG_LINE_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    write_reg(REG_THRESHOLD, 0);
    queue_frame(3, 3, 1);
    queue_frame(3, 3, 2);
    drain();

    // Extreme kernels: all most-negative and all most-positive taps, max threshold
    write_reg(REG_COEFF_X, 36'h888888888);
    write_reg(REG_COEFF_Y, 36'h777777777);
    write_reg(REG_THRESHOLD, 255);
    queue_frame(4, 3, 1);
    drain();
    write_reg(REG_THRESHOLD, 100);
    // Frame start mid-frame, and an unmarked wrap into the next frame
    queue_frame(3, 3, 0);
    for (int i = 0; i < 4; i++) pending_pixels.push_back('{pixel: 8'hFF, frame_start: 1'b0});
    queue_frame(3, 3, 0);
    for (int i = 0; i < 9; i++)
      pending_pixels.push_back('{pixel: 8'($urandom_range(0, 255)), frame_start: 1'b0});
    drain();

    // Out-of-range bounds act as clamped values
    write_reg(REG_LINE_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 2047);
    queue_frame(3, 4, 0);
    drain();

    // Long receiver hold-off while pixels keep coming
    write_reg(REG_LINE_WIDTH, 5);
    write_reg(REG_FRAME_HEIGHT, 5);
    hold_off = 1'b1;
    queue_frame(5, 5, 0);
    while (hold_cycles < 300) @(posedge clk);
    hold_off = 1'b0;
    drain();

    // Random frames with random kernels and bounds
    while (pixels_sent < 450) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 40) : $urandom_range(3, 8);
      h = $urandom_range(3, 6);
      write_reg(REG_COEFF_X, {4'($urandom_range(0, 15)), $urandom()});
      write_reg(REG_COEFF_Y, {4'($urandom_range(0, 15)), $urandom()});
      write_reg(REG_THRESHOLD, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 80));
      write_reg(REG_LINE_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      if (pixels_sent > 370) calm = 1'b1;
      queue_frame(w, h, $urandom_range(0, 3) == 0 ? 2 : 0);
      // Occasionally run an unmarked second frame on the same stores
      if ($urandom_range(0, 3) == 0)
        for (int i = 0; i < w * h; i++) begin
          p.pixel = 8'($urandom_range(0, 255));
          p.frame_start = 1'b0;
          pending_pixels.push_back(p);
        end
      drain();
    end

    drain();
    $display("covered %0d pixels, %0d results, clamped bounds, mid-frame marks,",
             pixels_sent, results_seen);
    $display("extreme kernels and thresholds, random stalls and one long output hold");
    if (errors == 0 && expected_edges.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
